@@ hw/rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and sizing constants for the sorted stream merge core.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Value width carried through the queues
  localparam int VALUE_W     = 32;

  // List codes
  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  // One pushed element
  typedef struct packed {
    logic                      list_select;
    logic signed [VALUE_W-1:0] element_value;
    logic                      list_end;
  } ssm_in_t;

  // One merged result
  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      source_list;
    logic                      merge_last;
    logic                      overflow;
  } ssm_out_t;

endpackage

@@ hw/rtl/sorted_stream_merge_core.sv @@
// ----------------------------------------------------------------------------
// sorted_stream_merge_core
// Two-way merge of two ascending signed sequences held in bounded queues.
// ----------------------------------------------------------------------------
// Each push request carries one value for list A or list B and is queued
// (QUEUE_DEPTH entries per list). After the push, a small sequencer emits every
// merged value that can now be decided: the smaller queue head (A on a tie), or
// the remaining queue once the other list has ended. The value that empties both
// queues with both lists ended carries merge_last and re-arms the end flags. A
// push into a full queue returns a single overflow result and changes nothing.
// Sequence: a push is accepted in idle; each result then takes a decide step and
// a send step that holds until the output side takes it, and a final decide step
// that finds nothing to emit returns to idle. An overflow goes to the send step,
// then to a decide step. The single head compare and pop path is reused for every
// result, and push_ready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
module sorted_stream_merge_core
  import ssm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  ssm_in_t  push_data,
  output logic     merge_valid,
  input  logic     merge_ready,
  output ssm_out_t merge_data
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PICK = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [1:0]       state, state_next;
  logic [PTR_W-1:0] head_a, head_a_next, head_b, head_b_next;
  logic [CNT_W-1:0] cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic             ended_a, ended_a_next, ended_b, ended_b_next;
  ssm_out_t         result, result_next;

  logic signed [VALUE_W-1:0] store_a [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] store_b [QUEUE_DEPTH];

  logic             push_acc;
  logic [PTR_W-1:0] sel_head;
  logic [CNT_W-1:0] sel_cnt;
  logic [CNT_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic             sel_full;
  logic             wr_a, wr_b;

  logic signed [VALUE_W-1:0] head_val_a, head_val_b;
  logic             have_a, have_b, b_less;
  logic             pop_a, pop_b;
  logic [CNT_W-1:0] cnt_a_pop, cnt_b_pop;
  logic             last_now;

  assign push_ready  = (state == S_IDLE);
  assign merge_valid = (state == S_SEND);
  assign merge_data  = result;
  assign push_acc    = push_valid && push_ready;

  // Locate the write slot of the selected queue
  assign sel_head = (push_data.list_select == LIST_B) ? head_b : head_a;
  assign sel_cnt  = (push_data.list_select == LIST_B) ? cnt_b : cnt_a;
  assign sel_full = (sel_cnt == CNT_FULL);
  assign tail_sum = {1'b0, CNT_W'(sel_head)} + {1'b0, sel_cnt};
  assign tail     = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                    : PTR_W'(tail_sum);
  assign wr_a     = push_acc && !sel_full && (push_data.list_select == LIST_A);
  assign wr_b     = push_acc && !sel_full && (push_data.list_select == LIST_B);

  // Shared head compare
  assign head_val_a = store_a[head_a];
  assign head_val_b = store_b[head_b];
  assign have_a     = (cnt_a != '0);
  assign have_b     = (cnt_b != '0);
  assign b_less     = (head_val_b < head_val_a);

  // Decide which queue pops, if any
  always_comb begin
    pop_a = 1'b0;
    pop_b = 1'b0;
    if (have_a && have_b) begin
      pop_b = b_less;
      pop_a = !b_less;
    end else if (have_a && ended_b) begin
      pop_a = 1'b1;
    end else if (have_b && ended_a) begin
      pop_b = 1'b1;
    end
  end

  assign cnt_a_pop = pop_a ? cnt_a - CNT_W'(1) : cnt_a;
  assign cnt_b_pop = pop_b ? cnt_b - CNT_W'(1) : cnt_b;
  assign last_now  = ended_a && ended_b && (cnt_a_pop == '0) && (cnt_b_pop == '0);

  // Sequencer and queue bookkeeping
  always_comb begin
    state_next   = state;
    head_a_next  = head_a;
    head_b_next  = head_b;
    cnt_a_next   = cnt_a;
    cnt_b_next   = cnt_b;
    ended_a_next = ended_a;
    ended_b_next = ended_b;
    result_next  = result;
    unique case (state)
      S_IDLE: begin
        if (push_acc) begin
          if (sel_full) begin
            // Refuse the request outright
            result_next          = '0;
            result_next.overflow = 1'b1;
            state_next           = S_SEND;
          end else begin
            if (push_data.list_select == LIST_B) begin
              cnt_b_next   = cnt_b + CNT_W'(1);
              ended_b_next = ended_b || push_data.list_end;
            end else begin
              cnt_a_next   = cnt_a + CNT_W'(1);
              ended_a_next = ended_a || push_data.list_end;
            end
            state_next = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (pop_a || pop_b) begin
          result_next.merged_value = pop_b ? head_val_b : head_val_a;
          result_next.source_list  = pop_b ? LIST_B : LIST_A;
          result_next.merge_last   = last_now;
          result_next.overflow     = 1'b0;
          cnt_a_next = cnt_a_pop;
          cnt_b_next = cnt_b_pop;
          if (pop_a) begin
            head_a_next = (head_a == PTR_LAST) ? '0 : head_a + PTR_W'(1);
          end
          if (pop_b) begin
            head_b_next = (head_b == PTR_LAST) ? '0 : head_b + PTR_W'(1);
          end
          // Re-arm the end flags for the next merge
          if (last_now) begin
            ended_a_next = 1'b0;
            ended_b_next = 1'b0;
          end
          state_next = S_SEND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SEND: begin
        // Hold the result until taken, then look for the next one
        if (merge_ready) begin
          state_next = S_PICK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head_a  <= '0;
      head_b  <= '0;
      cnt_a   <= '0;
      cnt_b   <= '0;
      ended_a <= 1'b0;
      ended_b <= 1'b0;
    end else begin
      state   <= state_next;
      head_a  <= head_a_next;
      head_b  <= head_b_next;
      cnt_a   <= cnt_a_next;
      cnt_b   <= cnt_b_next;
      ended_a <= ended_a_next;
      ended_b <= ended_b_next;
    end
  end

  // Result register and queue storage
  always_ff @(posedge clk) begin
    result <= result_next;
    if (wr_a) begin
      store_a[tail] <= push_data.element_value;
    end
    if (wr_b) begin
      store_b[tail] <= push_data.element_value;
    end
  end

  // Checks
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    push_ready |-> !merge_valid)
    else $error("push accepted while a result is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CNT_FULL) && (cnt_b <= CNT_FULL))
    else $error("queue count exceeds depth");

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    (merge_valid && merge_data.overflow) |->
      (merge_data.merged_value == '0) && !merge_data.merge_last
      && (merge_data.source_list == LIST_A))
    else $error("overflow result carries data");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (merge_valid && merge_data.merge_last) |->
      (cnt_a == '0) && (cnt_b == '0) && !ended_a && !ended_b)
    else $error("merge_last with data or end flags left");

endmodule

@@ tb/ssm_merge_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssm_merge_checker
// Watches both channels of the sorted stream merge core and scores results.
// ----------------------------------------------------------------------------
// Every accepted push request updates a private copy of the two list queues
// and end flags. The merge results that this request makes decidable are
// queued in order. Each accepted merge result is compared field by field with
// the oldest queued one. The counts go back to the top for the verdict.
// ----------------------------------------------------------------------------
module ssm_merge_checker
  import ssm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  logic     push_ready,
  input  ssm_in_t  push_data,
  input  logic     merge_valid,
  input  logic     merge_ready,
  input  ssm_out_t merge_data,
  output int       error_count,
  output int       pending,
  output int       pushes_seen,
  output int       results_seen,
  output int       overflows_seen,
  output int       merges_closed
);

  // Private copy of the queues: index 0 is list A, index 1 is list B
  logic signed [VALUE_W-1:0] lane_store [2][QUEUE_DEPTH];
  int                        lane_head  [2];
  int                        lane_fill  [2];
  logic                      lane_ended [2];

  // Merge results still owed by the block, oldest first
  ssm_out_t merged_expect [$];

  // Apply one push request and queue every result it makes decidable
  task automatic predict_push(input ssm_in_t req);
    int                        s;
    int                        t;
    int                        n;
    logic                      take_b;
    logic signed [VALUE_W-1:0] v;
    ssm_out_t                  r;
    s = (req.list_select == LIST_B) ? 1 : 0;
    // Refuse a push into a full queue, end flag included
    if (lane_fill[s] >= QUEUE_DEPTH) begin
      r = '0;
      r.overflow = 1'b1;
      merged_expect.push_back(r);
      return;
    end
    lane_store[s][(lane_head[s] + lane_fill[s]) % QUEUE_DEPTH] = req.element_value;
    lane_fill[s]++;
    if (req.list_end) begin
      lane_ended[s] = 1'b1;
    end
    n = 0;
    while (n < 2 * QUEUE_DEPTH) begin
      // Pick the smaller head, A on a tie, or drain once the other list ended
      if (lane_fill[0] > 0 && lane_fill[1] > 0) begin
        take_b = lane_store[1][lane_head[1]] < lane_store[0][lane_head[0]];
      end else if (lane_fill[0] > 0 && lane_ended[1]) begin
        take_b = 1'b0;
      end else if (lane_fill[1] > 0 && lane_ended[0]) begin
        take_b = 1'b1;
      end else begin
        break;
      end
      t = take_b ? 1 : 0;
      v = lane_store[t][lane_head[t]];
      lane_head[t] = (lane_head[t] + 1) % QUEUE_DEPTH;
      lane_fill[t]--;
      r = '0;
      r.merged_value = v;
      r.source_list  = take_b ? LIST_B : LIST_A;
      // Close the merge when both lists ended and both queues ran dry
      if (lane_ended[0] && lane_ended[1] && lane_fill[0] == 0 && lane_fill[1] == 0) begin
        r.merge_last  = 1'b1;
        lane_ended[0] = 1'b0;
        lane_ended[1] = 1'b0;
      end
      merged_expect.push_back(r);
      n++;
    end
  endtask

  // Predict on push requests, score merge results
  always @(posedge clk) begin
    ssm_out_t want;
    if (rst) begin
      lane_head[0]  = 0;
      lane_head[1]  = 0;
      lane_fill[0]  = 0;
      lane_fill[1]  = 0;
      lane_ended[0] = 1'b0;
      lane_ended[1] = 1'b0;
      merged_expect.delete();
      error_count    = 0;
      pending        = 0;
      pushes_seen    = 0;
      results_seen   = 0;
      overflows_seen = 0;
      merges_closed  = 0;
    end else begin
      if (push_valid && push_ready) begin
        pushes_seen++;
        predict_push(push_data);
      end
      if (merge_valid && merge_ready) begin
        results_seen++;
        if (merged_expect.size() == 0) begin
          error_count++;
          $display("%0t: unexpected merge result: value %0d list %0b last %0b ovf %0b",
                   $time, merge_data.merged_value, merge_data.source_list,
                   merge_data.merge_last, merge_data.overflow);
        end else begin
          want = merged_expect.pop_front();
          if (want.overflow) overflows_seen++;
          if (want.merge_last) merges_closed++;
          if (merge_data.merged_value !== want.merged_value ||
              merge_data.source_list  !== want.source_list  ||
              merge_data.merge_last   !== want.merge_last   ||
              merge_data.overflow     !== want.overflow) begin
            error_count++;
            $display("%0t: merge result mismatch: expected value %0d list %0b last %0b ovf %0b",
                     $time, want.merged_value, want.source_list, want.merge_last,
                     want.overflow);
            $display("%0t:                          actual value %0d list %0b last %0b ovf %0b",
                     $time, merge_data.merged_value, merge_data.source_list,
                     merge_data.merge_last, merge_data.overflow);
          end
        end
      end
      pending = merged_expect.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted stream merge core.
// ----------------------------------------------------------------------------
// A short directed pass covers ties, extreme values, pushes after a list end,
// a full queue and unsorted input. Four pacing phases of random merges follow
// (no idling, idle sender, stalling receiver, both), mixed with bursts of
// unsorted pushes and random end flags. Scoring lives in ssm_merge_checker.
// ----------------------------------------------------------------------------
module tb
  import ssm_pkg::*;
();

  localparam int RUN_LIMIT   = 400000;
  localparam int PHASE_ITEMS = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic     clk;
  logic     rst;
  logic     push_valid;
  logic     push_ready;
  ssm_in_t  push_data;
  logic     merge_valid;
  logic     merge_ready;
  ssm_out_t merge_data;

  int error_count;
  int pending;
  int pushes_seen;
  int results_seen;
  int overflows_seen;
  int merges_closed;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_go;
  int cycle_count;

  sorted_stream_merge_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .merge_valid (merge_valid),
    .merge_ready (merge_ready),
    .merge_data  (merge_data)
  );

  ssm_merge_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data),
    .merge_valid    (merge_valid),
    .merge_ready    (merge_ready),
    .merge_data     (merge_data),
    .error_count    (error_count),
    .pending        (pending),
    .pushes_seen    (pushes_seen),
    .results_seen   (results_seen),
    .overflows_seen (overflows_seen),
    .merges_closed  (merges_closed)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on total run length
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit of %0d cycles reached, %0d results still owed",
             $time, RUN_LIMIT, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request
  initial begin
    int held;
    merge_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        merge_ready <= 1'b0;
        held = 1;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
      end else begin
        merge_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one push request and hold it until accepted
  task automatic offer_request(input logic sel, input logic signed [VALUE_W-1:0] val,
                               input logic fin);
    ssm_in_t req;
    req.list_select   = sel;
    req.element_value = val;
    req.list_end      = fin;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push_valid <= 1'b0;
      @(negedge clk);
    end
    push_valid <= 1'b1;
    push_data  <= req;
    do @(posedge clk); while (!push_ready);
    @(negedge clk);
  endtask

  // Hold the sender until every owed result has arrived
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Next value of an ascending list: ties, small steps or large jumps
  function automatic logic signed [VALUE_W-1:0] next_up(input logic signed [VALUE_W-1:0] cur);
    longint sum;
    case ($urandom_range(0, 3))
      0:       sum = longint'(cur);
      1, 2:    sum = longint'(cur) + longint'($urandom_range(1, 1000));
      default: sum = longint'(cur) + longint'($urandom_range(0, 32'h3fff_ffff));
    endcase
    if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
    return sum[VALUE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] list_start();
    case ($urandom_range(0, 3))
      0:       return VAL_MIN + $urandom_range(0, 1000);
      1:       return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int list_length();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
  endfunction

  // Push one well-formed merge: two ascending lists, randomly interleaved
  task automatic send_merge(inout int sent);
    int                        remain  [2];
    logic signed [VALUE_W-1:0] cur     [2];
    bit                        started [2];
    int                        s;
    remain[0]  = list_length();
    remain[1]  = list_length();
    cur[0]     = list_start();
    cur[1]     = ($urandom_range(0, 3) == 0) ? cur[0] : list_start();
    started[0] = 1'b0;
    started[1] = 1'b0;
    while (remain[0] + remain[1] > 0) begin
      if (remain[0] == 0) s = 1;
      else if (remain[1] == 0) s = 0;
      else s = $urandom_range(0, 1);
      if (started[s]) cur[s] = next_up(cur[s]);
      started[s] = 1'b1;
      remain[s]--;
      offer_request((s == 1) ? LIST_B : LIST_A, cur[s], remain[s] == 0);
      sent++;
    end
  endtask

  // Push a short burst of unsorted values with stray end flags
  task automatic send_noise(inout int sent);
    int burst;
    burst = $urandom_range(1, 6);
    repeat (burst) begin
      offer_request($urandom_range(0, 1) ? LIST_B : LIST_A, $urandom,
                    $urandom_range(0, 3) == 0);
      sent++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int sent;
    rst            = 1'b1;
    push_valid     = 1'b0;
    push_data      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    sent           = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ties at the minimum, extremes, and a push after list A has ended
    offer_request(LIST_A, VAL_MIN, 1'b0);
    offer_request(LIST_B, VAL_MIN, 1'b0);
    offer_request(LIST_A, -1, 1'b0);
    offer_request(LIST_B, 0, 1'b0);
    offer_request(LIST_A, 5, 1'b1);
    offer_request(LIST_A, 7, 1'b0);
    offer_request(LIST_B, VAL_MAX, 1'b1);

    // Fill queue A with unsorted values, overflow it, then close both lists
    repeat (QUEUE_DEPTH + 1) offer_request(LIST_A, $urandom, 1'b0);
    offer_request(LIST_B, VAL_MAX, 1'b1);
    offer_request(LIST_A, 100, 1'b1);
    wait_drained();

    // Random merges under four pacing phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // Back up the output while the sender keeps offering
      if (phase == 0) hold_go = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) send_noise(sent);
        else send_merge(sent);
      end
      wait_drained();
    end

    push_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d push requests and %0d merge results (%0d overflow refusals,",
             pushes_seen, results_seen, overflows_seen);
    $display("%0d completed merges) across four handshake pacing phases.", merges_closed);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d merge result errors", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
